/* design/sha1_pkg.sv */
// sha1_pkg: shared types, constants and helper functions of the sha-1 engine
// no dependencies; used by sha1_round, sha1_hash_engine and tb_sha1_hash_engine
package sha1_pkg;

  // block geometry
  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 5;
  localparam int ROUNDS      = 80;
  localparam logic [5:0] LEN_AT   = 6'd56;
  localparam logic [5:0] FILL_MAX = 6'd63;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // initial chaining values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_WB,
    ST_DIG_RD,
    ST_DIG_LD
  } sha1_state_t;

  // five working variables
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_work_t;

  // initial value of one chaining word
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = IV0;
      3'd1: v = IV1;
      3'd2: v = IV2;
      3'd3: v = IV3;
      3'd4: v = IV4;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round constant for round number rnd
  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

/* design/sha1_hash_engine.sv */
// sha1_hash_engine: sha-1 over a byte stream, block words and chaining words in ram
// depends on sha1_pkg, sha1_ram and sha1_round
//
// usage: each input beat carries an optional message byte (in_byte_present)
// and an optional end mark (in_end_of_message). an end beat yields five output
// beats, digest words 0 to 4, out_last_word high on word 4.
// bytes are taken one per cycle while the current 64-byte block fills; bytes
// pack into 32-bit words written to a 16-word block ram.
// the 64th byte starts compression: the block ram is loaded into the schedule
// window and the chaining ram into the working variables, the rounds run one
// per cycle, and the result is added back into the chaining ram.
// an end beat adds 9 to 72 padding and length bytes, one or two
// compressions, then moves each digest word from the chaining ram into the
// output register.
// in_ready is low during padding, compression and digest readout.
// after reset the chaining ram reads as the initial values through a fresh
// flag, so no clearing pass is needed; the same flag restarts each message.
// when the receiver stalls, the output register holds its word; word 4 may
// wait there while the next message is already being taken.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  // control registers
  sha1_pkg::sha1_state_t state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic        pad_r, pad_nxt;
  logic        mark_r, mark_nxt;
  logic        len_r, len_nxt;
  logic        fresh_r, fresh_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [2:0]  dig_idx_r, dig_idx_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload registers
  sha1_pkg::sha1_work_t work_r, work_nxt;
  logic [31:0] win_r [sha1_pkg::BLOCK_WORDS];
  logic [31:0] win_nxt [sha1_pkg::BLOCK_WORDS];
  logic [23:0] wbuf_r, wbuf_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_num_r, out_num_nxt;
  logic        out_last_r, out_last_nxt;

  // ram ports
  logic        wram_we, wram_re;
  logic [3:0]  wram_waddr, wram_raddr;
  logic [31:0] wram_wdata, wram_rdata;
  logic        hram_we, hram_re;
  logic [2:0]  hram_waddr, hram_raddr;
  logic [31:0] hram_wdata, hram_rdata;

  // helpers
  logic        put_en;
  logic [7:0]  put_val;
  logic [6:0]  cnt_m1;
  logic [31:0] hval;
  logic [31:0] work_sel;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [31:0] sched_x;
  logic [31:0] sched_new;
  sha1_pkg::sha1_work_t round_out;

  // block word store, 16 words of 32 bits
  sha1_ram #(.WIDTH(32), .DEPTH(sha1_pkg::BLOCK_WORDS)) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (wram_re),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  // chaining word store, 5 words of 32 bits
  sha1_ram #(.WIDTH(32), .DEPTH(sha1_pkg::HASH_WORDS)) u_hram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .re    (hram_re),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  // one compression round
  sha1_round u_round (
    .work_i (work_r),
    .wt_i   (win_r[0]),
    .rnd_i  (cnt_r),
    .work_o (round_out)
  );

  assign cnt_m1   = cnt_r - 7'd1;
  // chaining word as stored, or the initial value at the start of a message
  assign hval     = fresh_r ? sha1_pkg::iv_word(cnt_m1[2:0]) : hram_rdata;
  assign bit_len  = {msg_r[60:0], 3'b000};
  assign len_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];
  assign sched_x  = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  // working variable picked for write-back
  always_comb begin
    case (cnt_m1[2:0])
      3'd0: work_sel = work_r.a;
      3'd1: work_sel = work_r.b;
      3'd2: work_sel = work_r.c;
      3'd3: work_sel = work_r.d;
      3'd4: work_sel = work_r.e;
      default: work_sel = '0;
    endcase
  end

  // sequencer: next state, byte path, ram control
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    len_nxt       = len_r;
    fresh_nxt     = fresh_r;
    cnt_nxt       = cnt_r;
    dig_idx_nxt   = dig_idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    work_nxt      = work_r;
    win_nxt       = win_r;
    wbuf_nxt      = wbuf_r;
    out_word_nxt  = out_word_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    put_en        = 1'b0;
    put_val       = '0;
    wram_re       = 1'b0;
    wram_raddr    = cnt_r[3:0];
    hram_re       = 1'b0;
    hram_raddr    = cnt_r[2:0];
    hram_we       = 1'b0;
    hram_waddr    = cnt_m1[2:0];
    hram_wdata    = hval + work_sel;

    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            msg_nxt = msg_r + 64'd1;
            put_en  = 1'b1;
            put_val = in_data_byte;
          end
          if (in_end_of_message) begin
            pad_nxt   = 1'b1;
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end

      // padding mark, zeros, then the bit length
      sha1_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (!mark_r) begin
          put_val  = sha1_pkg::PAD_MARK;
          mark_nxt = 1'b1;
        end else if (len_r || fill_r == sha1_pkg::LEN_AT) begin
          put_val = len_byte;
          len_nxt = 1'b1;
        end else begin
          put_val = 8'h00;
        end
      end

      // block ram into schedule window, chaining ram into working variables
      sha1_pkg::ST_LOAD: begin
        wram_re = cnt_r < 7'(sha1_pkg::BLOCK_WORDS);
        hram_re = cnt_r < 7'(sha1_pkg::HASH_WORDS);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r != 7'd0) begin
          for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[sha1_pkg::BLOCK_WORDS-1] = wram_rdata;
        end
        if (cnt_r != 7'd0 && cnt_r <= 7'(sha1_pkg::HASH_WORDS)) begin
          work_nxt.a = work_r.b;
          work_nxt.b = work_r.c;
          work_nxt.c = work_r.d;
          work_nxt.d = work_r.e;
          work_nxt.e = hval;
        end
        if (cnt_r == 7'(sha1_pkg::BLOCK_WORDS)) begin
          cnt_nxt   = '0;
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end

      // one round per cycle, window always holds w[t] at the bottom
      sha1_pkg::ST_ROUND: begin
        work_nxt = round_out;
        for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[sha1_pkg::BLOCK_WORDS-1] = sched_new;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(sha1_pkg::ROUNDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = sha1_pkg::ST_WB;
        end
      end

      // read chaining word k, write back word k-1 plus its working variable
      sha1_pkg::ST_WB: begin
        hram_re = cnt_r < 7'(sha1_pkg::HASH_WORDS);
        hram_we = cnt_r != 7'd0;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(sha1_pkg::HASH_WORDS)) begin
          cnt_nxt   = '0;
          fresh_nxt = 1'b0;
          if (len_r) begin
            dig_idx_nxt = '0;
            state_nxt   = sha1_pkg::ST_DIG_RD;
          end else if (pad_r) begin
            state_nxt = sha1_pkg::ST_PAD;
          end else begin
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end

      sha1_pkg::ST_DIG_RD: begin
        hram_re    = 1'b1;
        hram_raddr = dig_idx_r;
        state_nxt  = sha1_pkg::ST_DIG_LD;
      end

      // move one digest word into the output register once it is free
      sha1_pkg::ST_DIG_LD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hram_rdata;
          out_num_nxt   = dig_idx_r;
          out_last_nxt  = dig_idx_r == sha1_pkg::LAST_WORD_IDX;
          if (dig_idx_r == sha1_pkg::LAST_WORD_IDX) begin
            fresh_nxt = 1'b1;
            msg_nxt   = '0;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            len_nxt   = 1'b0;
            state_nxt = sha1_pkg::ST_IDLE;
          end else begin
            dig_idx_nxt = dig_idx_r + 3'd1;
            state_nxt   = sha1_pkg::ST_DIG_RD;
          end
        end
      end

      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase

    // shared byte path: pack into words, start compression on a full block
    if (put_en) begin
      wbuf_nxt = {wbuf_r[15:0], put_val};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == sha1_pkg::FILL_MAX) begin
        cnt_nxt   = '0;
        state_nxt = sha1_pkg::ST_LOAD;
      end
    end
  end

  assign wram_we    = put_en && (fill_r[1:0] == 2'b11);
  assign wram_waddr = fill_r[5:2];
  assign wram_wdata = {wbuf_r, put_val};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      fill_r      <= '0;
      msg_r       <= '0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      fresh_r     <= 1'b1;
      cnt_r       <= '0;
      dig_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      len_r       <= len_nxt;
      fresh_r     <= fresh_nxt;
      cnt_r       <= cnt_nxt;
      dig_idx_r   <= dig_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    win_r      <= win_nxt;
    wbuf_r     <= wbuf_nxt;
    out_word_r <= out_word_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_number = out_num_r;
  assign out_last_word   = out_last_r;

endmodule

/* design/sha1_ram.sv */
// sha1_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sha1_round.sv */
// sha1_round: one sha-1 compression round on the working variables
// depends on sha1_pkg (sha1_work_t, round_k)
module sha1_round (
  input  sha1_pkg::sha1_work_t work_i,
  input  logic [31:0]          wt_i,
  input  logic [6:0]           rnd_i,
  output sha1_pkg::sha1_work_t work_o
);

  logic [31:0] f;
  logic [31:0] rot_a;

  // boolean function by round group
  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
    end else if (rnd_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
    end else if (rnd_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
    end
  end

  assign rot_a = {work_i.a[26:0], work_i.a[31:27]};

  // new a and rotate the others down
  always_comb begin
    work_o.a = rot_a + f + work_i.e + sha1_pkg::round_k(rnd_i) + wt_i;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

/* design/sha1_checker.sv */
// sha1_checker: port-level assertions for sha1_hash_engine, attached by bind
// depends only on the top level's ports
module sha1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_byte_present,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_number,
  input logic        out_last_word
);

  // a stalled output beat holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_number))
    else $error("stalled digest beat changed");

  // last flag only on word four
  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_number == 3'd4)))
    else $error("last_word does not match word_number");

  // no new input while an early digest word is pending
  a_no_in_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> !in_ready)
    else $error("input taken during digest readout");

  // an end beat stops input for padding
  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("input ready right after end of message");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (.*);

/* verif/tb_sha1_hash_engine.sv */
// tb_sha1_hash_engine: self-checking bench for the sha-1 byte stream engine
// drives message beats, predicts each digest in place and checks every output beat
// depends on sha1_pkg and sha1_hash_engine
module tb_sha1_hash_engine;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BEATS  = 410;
  localparam int CALM_TAIL    = 60;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;

  sha1_hash_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_word  (out_digest_word),
    .out_word_number  (out_word_number),
    .out_last_word    (out_last_word)
  );

  msg_beat_t    beat_queue[$];
  digest_beat_t digest_q[$];
  int           in_accepted = 0;
  int           drv_issued = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           mismatches = 0;

  // predictor state
  logic [31:0] hash_chain [5];
  logic [7:0]  block_buf [64];
  logic [5:0]  fill_cnt;
  logic [63:0] msg_len;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic restart_hash();
    hash_chain[0] = sha1_pkg::IV0;
    hash_chain[1] = sha1_pkg::IV1;
    hash_chain[2] = sha1_pkg::IV2;
    hash_chain[3] = sha1_pkg::IV3;
    hash_chain[4] = sha1_pkg::IV4;
    fill_cnt = '0;
    msg_len = '0;
  endtask

  // 80 rounds over the buffered block, added into the chaining words
  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, x, sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[t*4], block_buf[t*4+1], block_buf[t*4+2], block_buf[t*4+3]};
    end
    for (int t = 16; t < 80; t++) begin
      x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
      w[t] = {x[30:0], x[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_chain[0] = hash_chain[0] + a;
    hash_chain[1] = hash_chain[1] + b;
    hash_chain[2] = hash_chain[2] + c;
    hash_chain[3] = hash_chain[3] + d;
    hash_chain[4] = hash_chain[4] + e;
  endtask

  task automatic put_byte(input logic [7:0] v);
    block_buf[fill_cnt] = v;
    fill_cnt = fill_cnt + 6'd1;
    if (fill_cnt == 6'd0) begin
      compress_block();
    end
  endtask

  // one accepted beat; an end beat pads, finishes and queues five digest words
  task automatic hash_step(input logic [7:0] data, input logic present, input logic last);
    logic [63:0]  bit_len;
    digest_beat_t word;
    if (present) begin
      msg_len = msg_len + 64'd1;
      put_byte(data);
    end
    if (!last) begin
      return;
    end
    bit_len = msg_len << 3;
    put_byte(sha1_pkg::PAD_MARK);
    while (fill_cnt != sha1_pkg::LEN_AT) begin
      put_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      put_byte(bit_len[63 - i*8 -: 8]);
    end
    for (int i = 0; i < 5; i++) begin
      word.digest_word = hash_chain[i];
      word.word_number = 3'(i);
      word.last_word   = (word.word_number == sha1_pkg::LAST_WORD_IDX);
      digest_q.push_back(word);
    end
    restart_hash();
  endtask

  task automatic push_beat(input logic [7:0] data, input logic present, input logic last);
    msg_beat_t b;
    b.data_byte      = data;
    b.byte_present   = present;
    b.end_of_message = last;
    beat_queue.push_back(b);
  endtask

  // one message of random bytes; the end rides on the last byte or comes alone
  task automatic queue_message(input int len, input bit end_on_byte, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_beat(8'($urandom), 1'b0, 1'b0);
      end
      push_beat(8'($urandom), 1'b1, (i == len - 1) && end_on_byte);
    end
    if (len == 0 || !end_on_byte) begin
      push_beat(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // input driver: holds each beat until accepted, random gaps between beats
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted == drv_issued) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (beat_queue.size() > CALM_TAIL && $urandom_range(4) == 0) begin
          in_gap <= $urandom_range(4);
          in_valid <= 1'b0;
        end else if (beat_queue.size() > 0) begin
          in_data_byte      <= beat_queue[0].data_byte;
          in_byte_present   <= beat_queue[0].byte_present;
          in_end_of_message <= beat_queue[0].end_of_message;
          void'(beat_queue.pop_front());
          in_valid <= 1'b1;
          drv_issued <= drv_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (beat_queue.size() > CALM_TAIL && $urandom_range(4) == 0) begin
        out_gap <= $urandom_range(4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_accepted <= in_accepted + 1;
        hash_step(in_data_byte, in_byte_present, in_end_of_message);
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest beat", out_digest_word, 32'h0);
        end else begin
          if (out_digest_word !== digest_q[0].digest_word) begin
            report_mismatch("digest_word", out_digest_word, digest_q[0].digest_word);
          end
          if (out_word_number !== digest_q[0].word_number) begin
            report_mismatch("word_number", 32'(out_word_number),
                            32'(digest_q[0].word_number));
          end
          if (out_last_word !== digest_q[0].last_word) begin
            report_mismatch("last_word", 32'(out_last_word), 32'(digest_q[0].last_word));
          end
          void'(digest_q.pop_front());
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int len;
    int boundary [12];
    boundary = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
    restart_hash();

    // empty message, then a beat with neither byte nor end
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hA5, 1'b0, 1'b0);
    // empty message again; the unused byte must be ignored
    push_beat(8'hFF, 1'b0, 1'b1);
    // single byte extremes, end on the byte
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b1);
    // "abc" with a separate end beat and a no-op beat inside
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h5A, 1'b0, 1'b0);
    push_beat(8'h63, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b1);
    // mixed bytes, end on the last one
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'h5A, 1'b1, 1'b1);

    // random messages, lengths weighted toward the padding boundaries
    while (beat_queue.size() < TOTAL_BEATS) begin
      if ($urandom_range(9) < 3) begin
        len = boundary[$urandom_range(11)];
      end else begin
        len = $urandom_range(40);
      end
      queue_message(len, $urandom_range(1), ($urandom_range(3) == 0) ? 0 : 8);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beat_queue.size() != 0 || in_accepted != drv_issued) begin
      @(posedge clk);
    end
    while (digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
